### design/krr_pkg.sv
// Shared types and codes of the keyed round-robin identifier table.
package krr_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_KEYS_FULL = 2'd2;
   localparam logic [1:0] ST_LIST_FULL = 2'd3;

   localparam int KEY_W  = 32;
   localparam int SLOT_W = 8;
   localparam int LEN_W  = 7;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic [LEN_W-1:0]  hit_len;
      logic              free;
      logic [SLOT_W-1:0] free_slot;
   } tok_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
   } upd_type;

endpackage

### design/krr_key_cell.sv
// One key slot: holds tag, valid bit and list length, and passes the search token on.
module krr_key_cell #(
   parameter int SLOT = 0,
   parameter int LW   = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  krr_pkg::tok_type tok_i,
   input  krr_pkg::upd_type upd_i,
   output krr_pkg::tok_type tok_o
);
   import krr_pkg::*;

   logic              valid_ff;
   logic [KEY_W-1:0]  tag_ff;
   logic [LW-1:0]     len_ff;
   tok_type           tok_ff;
   tok_type           tok_in;
   logic              match;
   logic              mine;

   assign match = valid_ff && (tag_ff == tok_i.key);
   assign mine  = upd_i.we && (upd_i.slot == SLOT_W'(SLOT));

   always_comb begin
      tok_in = tok_i;
      if (!tok_i.hit && match) begin
         tok_in.hit      = 1'b1;
         tok_in.hit_slot = SLOT_W'(SLOT);
         tok_in.hit_len  = LEN_W'(len_ff);
      end
      if (!tok_i.free && !valid_ff) begin
         tok_in.free      = 1'b1;
         tok_in.free_slot = SLOT_W'(SLOT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         len_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (mine) begin
            valid_ff <= 1'b1;
            len_ff   <= upd_i.len[LW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mine) begin
         tag_ff <= upd_i.tag;
      end
   end

   assign tok_o = tok_ff;

endmodule

### design/keyed_round_robin_id_table.sv
// Top level of the keyed round-robin identifier table.
// A request is taken when start is high and busy is low; busy falls in the cycle in which the
// single result is shown on the rsp_ ports with rsp_valid, and the receiver cannot stall, so the
// result must be taken in that cycle. The key search token walks the chain of key cells
// one slot a cycle; add then writes its identifier and key-cell update as the token leaves the
// chain, while remove and get stream the key's list of n entries through the identifier memory,
// one read and at most one write a cycle. An unknown operation skips the search entirely.
module keyed_round_robin_id_table #(
   parameter int KEY_SLOTS   = 16,
   parameter int IDS_PER_KEY = 8,
   parameter int ID_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_port_key,
   input  logic [31:0] req_service_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_selected_id
);
   import krr_pkg::*;

   localparam int SW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int LW    = $clog2(IDS_PER_KEY + 1);
   localparam int DEPTH = KEY_SLOTS * IDS_PER_KEY;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_LIST   = 3'd2;
   localparam logic [2:0] S_FIN    = 3'd3;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [SW-1:0]       slot_ff;
   logic [LW-1:0]       len_ff;
   logic [AW-1:0]       base_ff;
   logic [LW-1:0]       rd_cnt_ff;
   logic                rv_ff;
   logic [LW-1:0]       ridx_ff;
   logic [ID_WIDTH-1:0] rdata_ff;
   logic [ID_WIDTH-1:0] front_ff;
   logic                match_ff, match_in;
   logic                walked_ff;
   logic [1:0]          status_ff;
   logic                inject_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [ID_WIDTH-1:0] rsp_sel_ff;

   logic [ID_WIDTH-1:0] mem [DEPTH];
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [ID_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]       mem_raddr;

   tok_type             tok [KEY_SLOTS+1];
   tok_type             tok_head;
   upd_type             upd;
   tok_type             tok_out;

   logic [SW-1:0]       sel_slot;
   logic [LW-1:0]       sel_len;
   logic [AW-1:0]       base_calc;
   logic                accept;
   logic                last_data;

   generate
      if (ID_WIDTH <= 32) begin : g_narrow
         assign id_in           = req_service_id[ID_WIDTH-1:0];
         assign rsp_selected_id = 32'(rsp_sel_ff);
      end else begin : g_wide
         assign id_in           = {{(ID_WIDTH-32){1'b0}}, req_service_id};
         assign rsp_selected_id = rsp_sel_ff[31:0];
      end
   endgenerate

   always_comb begin
      tok_head       = '0;
      tok_head.valid = inject_ff;
      tok_head.key   = key_ff;
   end

   assign tok[0] = tok_head;

   genvar g;
   generate
      for (g = 0; g < KEY_SLOTS; g++) begin : g_cell
         krr_key_cell #(.SLOT(g), .LW(LW)) u_cell (
            .clock (clock),
            .reset (reset),
            .tok_i (tok[g]),
            .upd_i (upd),
            .tok_o (tok[g+1])
         );
      end
   endgenerate

   assign tok_out   = tok[KEY_SLOTS];
   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign sel_slot  = tok_out.hit ? tok_out.hit_slot[SW-1:0] : tok_out.free_slot[SW-1:0];
   assign sel_len   = tok_out.hit ? tok_out.hit_len[LW-1:0] : '0;
   assign base_calc = AW'(sel_slot) * AW'(IDS_PER_KEY);
   assign mem_raddr = base_ff + AW'(rd_cnt_ff);
   assign last_data = rv_ff && (ridx_ff == len_ff - LW'(1));

   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_waddr = base_ff;
      mem_wdata = rdata_ff;
      upd       = '0;
      match_in  = match_ff;
      case (state_ff)
         S_IDLE: begin
            match_in = 1'b0;
            if (accept) begin
               state_in = (req_operation == OP_ADD || req_operation == OP_REMOVE ||
                           req_operation == OP_GET) ? S_SEARCH : S_FIN;
            end
         end
         S_SEARCH: begin
            if (tok_out.valid) begin
               state_in = S_FIN;
               if (op_ff == OP_ADD) begin
                  if ((tok_out.hit || tok_out.free) && (32'(sel_len) < 32'(IDS_PER_KEY))) begin
                     mem_we    = 1'b1;
                     mem_waddr = base_calc + AW'(sel_len);
                     mem_wdata = id_ff;
                     upd.we    = 1'b1;
                     upd.slot  = SLOT_W'(sel_slot);
                     upd.tag   = key_ff;
                     upd.len   = LEN_W'(sel_len) + LEN_W'(1);
                  end
               end else if (tok_out.hit && (sel_len != '0)) begin
                  state_in = S_LIST;
               end
            end
         end
         S_LIST: begin
            if (rv_ff) begin
               if (op_ff == OP_GET) begin
                  if (ridx_ff != '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = base_ff + AW'(ridx_ff) - AW'(1);
                  end
               end else if (match_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = base_ff + AW'(ridx_ff) - AW'(1);
               end else if (rdata_ff == id_ff) begin
                  match_in = 1'b1;
               end
            end
            if (last_data) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
            if (walked_ff && op_ff == OP_GET) begin
               mem_we    = 1'b1;
               mem_waddr = base_ff + AW'(len_ff) - AW'(1);
               mem_wdata = front_ff;
            end
            if (walked_ff && op_ff == OP_REMOVE && status_ff == ST_OK) begin
               upd.we   = 1'b1;
               upd.slot = SLOT_W'(slot_ff);
               upd.tag  = key_ff;
               upd.len  = LEN_W'(len_ff) - LEN_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inject_ff    <= 1'b0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= accept && (state_in == S_SEARCH);
         rv_ff        <= (state_ff == S_LIST) && (rd_cnt_ff < len_ff);
         rsp_valid_ff <= (state_ff == S_FIN);
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff  <= rd_cnt_ff;
      match_ff <= match_in;
      if (accept) begin
         op_ff     <= req_operation;
         key_ff    <= req_port_key;
         id_ff     <= id_in;
         walked_ff <= 1'b0;
         status_ff <= ST_NOT_FOUND;
      end
      if (state_ff == S_SEARCH && tok_out.valid) begin
         slot_ff   <= sel_slot;
         len_ff    <= sel_len;
         base_ff   <= base_calc;
         rd_cnt_ff <= '0;
         if (op_ff == OP_ADD) begin
            if (!tok_out.hit && !tok_out.free) begin
               status_ff <= ST_KEYS_FULL;
            end else if (32'(sel_len) >= 32'(IDS_PER_KEY)) begin
               status_ff <= ST_LIST_FULL;
            end else begin
               status_ff <= ST_OK;
            end
         end else begin
            status_ff <= ST_NOT_FOUND;
         end
      end
      if (state_ff == S_LIST) begin
         if (rd_cnt_ff < len_ff) begin
            rd_cnt_ff <= rd_cnt_ff + LW'(1);
         end
         if (rv_ff && ridx_ff == '0) begin
            front_ff <= rdata_ff;
         end
         if (last_data) begin
            walked_ff <= 1'b1;
            status_ff <= (op_ff == OP_GET || match_in) ? ST_OK : ST_NOT_FOUND;
         end
      end
      if (state_ff == S_FIN) begin
         rsp_status_ff <= status_ff;
         rsp_sel_ff    <= (walked_ff && op_ff == OP_GET) ? front_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### design/krr_checker.sv
// Port-level checks of the keyed round-robin identifier table and their binding.
module krr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_selected_id
);
   import krr_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("A transfer was taken but busy did not rise.");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("A result appeared without a request in progress.");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two results were given for one request.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_selected_id == 32'd0)
      else $error("A failed request returned a non-zero identifier.");

endmodule

bind keyed_round_robin_id_table krr_checker u_krr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_selected_id (rsp_selected_id)
);

### verif/tb.sv
// Self-checking testbench of the keyed round-robin identifier table with a scoreboard class.
module tb;
   import krr_pkg::*;

   localparam int NUM_SLOTS = 16;
   localparam int LIST_DEPTH = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] selected_id;
   } answer_type;

   class id_table_scoreboard;
      logic [31:0] tags [NUM_SLOTS];
      bit          used [NUM_SLOTS];
      int          count [NUM_SLOTS];
      logic [31:0] ids [NUM_SLOTS][LIST_DEPTH];
      answer_type  pending [$];
      int          errors;

      function new();
         for (int s = 0; s < NUM_SLOTS; s++) begin
            tags[s] = '0;
            used[s] = 0;
            count[s] = 0;
         end
         errors = 0;
      endfunction

      function int find_key(logic [31:0] key);
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (used[s] && tags[s] == key) return s;
         end
         return -1;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] id);
         answer_type a;
         int s;
         int hit;
         logic [31:0] front;
         a.status = ST_NOT_FOUND;
         a.selected_id = '0;
         s = find_key(key);
         if (op == OP_ADD) begin
            if (s < 0) begin
               for (int f = 0; f < NUM_SLOTS; f++) begin
                  if (!used[f]) begin
                     s = f;
                     break;
                  end
               end
               if (s >= 0) begin
                  used[s] = 1;
                  tags[s] = key;
                  count[s] = 0;
               end
            end
            if (s < 0) begin
               a.status = ST_KEYS_FULL;
            end else if (count[s] >= LIST_DEPTH) begin
               a.status = ST_LIST_FULL;
            end else begin
               ids[s][count[s]] = id;
               count[s]++;
               a.status = ST_OK;
            end
         end else if (op == OP_REMOVE && s >= 0) begin
            hit = -1;
            for (int i = 0; i < count[s]; i++) begin
               if (hit < 0 && ids[s][i] == id) hit = i;
            end
            if (hit >= 0) begin
               for (int j = hit; j + 1 < count[s]; j++) ids[s][j] = ids[s][j+1];
               count[s]--;
               a.status = ST_OK;
            end
         end else if (op == OP_GET && s >= 0 && count[s] > 0) begin
            front = ids[s][0];
            for (int j = 0; j + 1 < count[s]; j++) ids[s][j] = ids[s][j+1];
            ids[s][count[s]-1] = front;
            a.status = ST_OK;
            a.selected_id = front;
         end
         pending.insert(pending.size(), a);
      endfunction

      function void check_answer(logic [1:0] status, logic [31:0] sel);
         answer_type e;
         if (pending.size() == 0) begin
            $error("unexpected transfer: status %0d selected_id %h", status, sel);
            errors++;
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            errors++;
         end
         if (sel !== e.selected_id) begin
            $error("selected_id: expected %h actual %h", e.selected_id, sel);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [31:0] req_port_key;
   logic [31:0] req_service_id;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_selected_id;

   id_table_scoreboard board;
   int cycles;
   logic [31:0] key_pool [6];
   logic [31:0] id_pool [4];

   keyed_round_robin_id_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_port_key(req_port_key),
      .req_service_id(req_service_id), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_selected_id(rsp_selected_id)
   );

   initial begin
      clock = 0;
      reset = 1;
      start = 0;
      req_operation = OP_ADD;
      req_port_key = '0;
      req_service_id = '0;
      board = new();
      cycles = 0;
   end

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[keyed_round_robin_id_table] ERROR");
         $finish;
      end
      if (!reset && rsp_valid) board.check_answer(rsp_status, rsp_selected_id);
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] id);
      start <= 1;
      req_operation <= op;
      req_port_key <= key;
      req_service_id <= id;
      do @(posedge clock); while (busy);
      board.note_request(op, key, id);
      idle_gap();
   endtask

   initial begin
      logic [1:0] op;
      logic [31:0] key;
      logic [31:0] id;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(OP_GET, 32'h0, 32'h0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'h0, 32'h0);
      send_request(OP_ADD, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h0, 32'h1234);
      send_request(OP_REMOVE, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h0, 32'h5);
      send_request(OP_REMOVE, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h0, 32'h0);
      send_request(OP_GET, 32'h0, 32'h0);
      for (int i = 0; i < 9; i++) send_request(OP_ADD, 32'hFFFF_FFFF, 32'(i));
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      for (int k = 1; k < 16; k++) send_request(OP_ADD, 32'hA000_0000 + 32'(k), 32'(k));
      send_request(OP_ADD, 32'h5555_AAAA, 32'h1);
      send_request(OP_GET, 32'hA000_0003, 32'h0);

      for (int i = 0; i < 6; i++) key_pool[i] = (i < 3) ? 32'hA000_0001 + 32'(i) : $urandom;
      for (int i = 0; i < 4; i++) id_pool[i] = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         op = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 29) == 0) op = OP_UNUSED;
         key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
         if ($urandom_range(0, 19) == 0) key = 32'hFFFF_FFFF;
         id = ($urandom_range(0, 4) == 0) ? $urandom : id_pool[$urandom_range(0, 3)];
         send_request(op, key, id);
      end
      start <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("[keyed_round_robin_id_table] OK");
      end else begin
         $display("[keyed_round_robin_id_table] ERROR");
      end
      $finish;
   end
endmodule
